@@ rtl/bed_pkg.sv @@
// Package for the escape-format binary string decoder.
// Holds character codes, escape phase codes, the queue packet type and sizes.
// No dependencies.
`default_nettype none
package bed_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NUL       = 8'h00;

    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_SLASH = 2'd1;
    localparam logic [1:0] PH_ONE   = 2'd2;
    localparam logic [1:0] PH_TWO   = 2'd3;

    localparam int DEF_COUNT_WIDTH = 16;
    localparam int REPORT_WIDTH    = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int MAX_EMIT        = 3;

    typedef logic [REPORT_WIDTH-1:0] t_report;

    typedef struct packed {
        logic [1:0]             n_bytes;
        logic [MAX_EMIT-1:0][7:0] bytes;
        t_report [MAX_EMIT-1:0] counts;
        logic                   last;
    } t_packet;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

@@ rtl/bed_in_if.sv @@
// Input channel of the decoder: one escaped byte and its end-of-string flag.
// No dependencies.
`default_nettype none
interface bed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

@@ rtl/bed_out_if.sv @@
// Output channel of the decoder: one decoded byte with its flags and count.
// No dependencies.
`default_nettype none
interface bed_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        out_last;
    logic [15:0] byte_count;

    modport source (output valid, output out_byte, output has_byte, output out_last,
                    output byte_count, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input out_last,
                    input byte_count, output ready);
endinterface
`default_nettype wire

@@ rtl/bed_front.sv @@
// Front part of the decoder: accepts input words, runs the escape phase machine
// and pushes the decoded bytes of each word as one packet. Uses bed_pkg, bed_in_if.
`default_nettype none
module bed_front
    import bed_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bed_in_if.sink      i_in,
    input  wire t_q_stat i_q_stat,
    output logic        o_push,
    output t_packet     o_packet
);

    localparam int EXT_W = (COUNT_WIDTH > REPORT_WIDTH) ? COUNT_WIDTH : REPORT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [EXT_W-1:0] REP_MAX = EXT_W'({REPORT_WIDTH{1'b1}});

    logic [1:0]             r_phase, n_phase;
    logic [1:0]             r_d1, n_d1;
    logic [2:0]             r_d2, n_d2;
    logic                   r_term, n_term;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;

    logic [7:0]             b;
    logic                   is_octal, is_low;
    logic                   do_fresh;
    logic [1:0]             e_n;
    logic [2:0][7:0]        e_byte;
    logic [COUNT_WIDTH-1:0] c1, c2, c3;
    logic                   accept;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == CNT_MAX) ? c : c + COUNT_WIDTH'(1);
    endfunction

    function automatic t_report report(input logic [COUNT_WIDTH-1:0] c);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(c);
        return (ext > REP_MAX) ? {REPORT_WIDTH{1'b1}} : ext[REPORT_WIDTH-1:0];
    endfunction

    assign b        = i_in.in_byte;
    assign is_octal = (b[7:3] == CH_ZERO[7:3]);
    assign is_low   = (b[7:2] == CH_ZERO[7:2]);
    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = !i_q_stat.full;

    always_comb begin
        n_phase  = r_phase;
        n_d1     = r_d1;
        n_d2     = r_d2;
        n_term   = r_term;
        e_n      = 2'd0;
        e_byte   = '0;
        do_fresh = 1'b0;
        if (!r_term) begin
            unique case (r_phase)
                PH_NONE: begin
                    do_fresh = 1'b1;
                end
                PH_SLASH: begin
                    if (b == CH_BACKSLASH) begin
                        n_phase   = PH_NONE;
                        e_byte[0] = CH_BACKSLASH;
                        e_n       = 2'd1;
                    end else if (is_low) begin
                        n_d1    = b[1:0];
                        n_phase = PH_ONE;
                    end else begin
                        n_phase  = PH_NONE;
                        do_fresh = 1'b1;
                    end
                end
                PH_ONE: begin
                    if (is_octal) begin
                        n_d2    = b[2:0];
                        n_phase = PH_TWO;
                    end else begin
                        n_phase   = PH_NONE;
                        e_byte[0] = CH_ZERO | 8'(r_d1);
                        e_n       = 2'd1;
                        do_fresh  = 1'b1;
                    end
                end
                PH_TWO: begin
                    n_phase = PH_NONE;
                    if (is_octal) begin
                        e_byte[0] = {r_d1, r_d2, b[2:0]};
                        e_n       = 2'd1;
                    end else begin
                        e_byte[0] = CH_ZERO | 8'(r_d1);
                        e_byte[1] = CH_ZERO | 8'(r_d2);
                        e_n       = 2'd2;
                        do_fresh  = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_NONE;
                end
            endcase
            if (do_fresh) begin
                if (b == CH_NUL) begin
                    n_term = 1'b1;
                end else if (b == CH_BACKSLASH) begin
                    n_phase = PH_SLASH;
                end else begin
                    e_byte[e_n] = b;
                    e_n         = e_n + 2'd1;
                end
            end
        end
        if (i_in.in_last && !n_term) begin
            if (n_phase == PH_ONE) begin
                e_byte[e_n] = CH_ZERO | 8'(n_d1);
                e_n         = e_n + 2'd1;
            end else if (n_phase == PH_TWO) begin
                e_byte[0] = CH_ZERO | 8'(n_d1);
                e_byte[1] = CH_ZERO | 8'(n_d2);
                e_n       = 2'd2;
            end
        end
    end

    assign c1 = sat_inc(r_cnt);
    assign c2 = sat_inc(c1);
    assign c3 = sat_inc(c2);

    always_comb begin
        unique case (e_n)
            2'd0:    n_cnt = r_cnt;
            2'd1:    n_cnt = c1;
            2'd2:    n_cnt = c2;
            default: n_cnt = c3;
        endcase
    end

    assign o_push             = accept && ((e_n != 2'd0) || i_in.in_last);
    assign o_packet.n_bytes   = e_n;
    assign o_packet.bytes     = e_byte;
    assign o_packet.counts[0] = (e_n == 2'd0) ? report(r_cnt) : report(c1);
    assign o_packet.counts[1] = report(c2);
    assign o_packet.counts[2] = report(c3);
    assign o_packet.last      = i_in.in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NONE;
            r_d1    <= '0;
            r_d2    <= '0;
            r_term  <= 1'b0;
            r_cnt   <= '0;
        end else if (accept) begin
            if (i_in.in_last) begin
                r_phase <= PH_NONE;
                r_d1    <= '0;
                r_d2    <= '0;
                r_term  <= 1'b0;
                r_cnt   <= '0;
            end else begin
                r_phase <= n_phase;
                r_d1    <= n_d1;
                r_d2    <= n_d2;
                r_term  <= n_term;
                r_cnt   <= n_cnt;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/bed_queue.sv @@
// Short packet queue between the front and back parts of the decoder.
// Uses bed_pkg.
`default_nettype none
module bed_queue
    import bed_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_packet i_packet,
    input  wire logic    i_pop,
    output t_packet      o_head,
    output t_q_stat      o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_packet       r_mem [DEPTH];
    logic [AW:0]   r_wr, r_rd;

    assign o_stat.empty = (r_wr == r_rd);
    assign o_stat.full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_head       = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_stat.full) begin
            r_mem[r_wr[AW-1:0]] <= i_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_stat.full) begin
                r_wr <= r_wr + (AW+1)'(1);
            end
            if (i_pop && !o_stat.empty) begin
                r_rd <= r_rd + (AW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/bed_back.sv @@
// Back part of the decoder: splits each queued packet into output words and
// holds the current word in an output register. Uses bed_pkg, bed_out_if.
`default_nettype none
module bed_back
    import bed_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_packet i_head,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    bed_out_if.source    o_out
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_has;
    logic       r_last;
    t_report    r_count;

    logic       take;
    logic [1:0] total;
    logic       final_word;

    assign take       = !r_valid || o_out.ready;
    assign total      = (i_head.n_bytes == 2'd0) ? 2'd1 : i_head.n_bytes;
    assign final_word = (r_idx == total - 2'd1);
    assign o_pop      = take && !i_q_stat.empty && final_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (take) begin
            r_valid <= !i_q_stat.empty;
            if (!i_q_stat.empty) begin
                r_idx <= final_word ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_q_stat.empty) begin
            r_byte  <= i_head.bytes[r_idx];
            r_has   <= (i_head.n_bytes != 2'd0);
            r_last  <= i_head.last && final_word;
            r_count <= i_head.counts[r_idx];
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.has_byte   = r_has;
    assign o_out.out_last   = r_last;
    assign o_out.byte_count = r_count;

endmodule
`default_nettype wire

@@ rtl/bytea_escape_decoder_core.sv @@
// Escape-format binary string decoder, top level.
// Uses bed_pkg, bed_in_if, bed_out_if, bed_front, bed_queue, bed_back.
//
// The decoder takes one escaped byte per cycle while its four-entry packet
// queue has room, and each byte yields zero to three output words. The output
// port moves one word per cycle while the receiver is ready, and that port
// sets the sustained rate. Each word passes through a queue entry and then
// the output register before it appears. The final word of each string
// carries out_last and the saturating byte count; it has no data byte when
// nothing was left to emit.
`default_nettype none
module bytea_escape_decoder_core
    import bed_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bed_in_if.sink    i_in,
    bed_out_if.source o_out
);

    t_packet packet;
    t_packet head;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    bed_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_packet (packet)
    );

    bed_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_packet (packet),
        .i_pop    (pop),
        .o_head   (head),
        .o_stat   (q_stat)
    );

    bed_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
`default_nettype wire

@@ dv/bed_decode_check.sv @@
// Checker for the escape-format binary string decoder: watches both channels,
// predicts the decoded words of every accepted input word and compares them in order.
// Depends on bed_pkg, bed_in_if and bed_out_if.
module bed_decode_check
    import bed_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bed_in_if         i_in_mon,
    bed_out_if        i_out_mon,
    output int        o_failures,
    output int        o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       last;
        t_report    count;
    } decoded_word_t;

    decoded_word_t expected_words[$];
    decoded_word_t step_words[$];

    logic [1:0]             esc_phase;
    logic [1:0]             held_hi;
    logic [2:0]             held_mid;
    logic [COUNT_WIDTH-1:0] decoded_count;
    logic                   string_ended;
    int                     failures = 0;

    function automatic t_report reported_count();
        longint unsigned c;
        c = decoded_count;
        return (c > 64'hFFFF) ? t_report'(16'hFFFF) : t_report'(c);
    endfunction

    function automatic logic is_octal_char(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_ZERO + 8'd7;
    endfunction

    task automatic clear_state();
        esc_phase     = PH_NONE;
        held_hi       = '0;
        held_mid      = '0;
        decoded_count = '0;
        string_ended  = 1'b0;
    endtask

    task automatic emit_decoded(input logic [7:0] b);
        if (decoded_count != '1) decoded_count++;
        step_words.push_back('{data: b, has_data: 1'b1, last: 1'b0, count: reported_count()});
    endtask

    task automatic take_plain(input logic [7:0] b);
        if (b == CH_NUL) begin
            string_ended = 1'b1;
        end else if (b == CH_BACKSLASH) begin
            esc_phase = PH_SLASH;
        end else begin
            emit_decoded(b);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic is_last);
        step_words.delete();
        if (!string_ended) begin
            case (esc_phase)
                PH_NONE: begin
                    take_plain(b);
                end
                PH_SLASH: begin
                    if (b == CH_BACKSLASH) begin
                        esc_phase = PH_NONE;
                        emit_decoded(CH_BACKSLASH);
                    end else if (b >= CH_ZERO && b <= CH_ZERO + 8'd3) begin
                        held_hi   = 2'(b - CH_ZERO);
                        esc_phase = PH_ONE;
                    end else begin
                        esc_phase = PH_NONE;
                        take_plain(b);
                    end
                end
                PH_ONE: begin
                    if (is_octal_char(b)) begin
                        held_mid  = 3'(b - CH_ZERO);
                        esc_phase = PH_TWO;
                    end else begin
                        esc_phase = PH_NONE;
                        emit_decoded(CH_ZERO + 8'(held_hi));
                        take_plain(b);
                    end
                end
                default: begin
                    esc_phase = PH_NONE;
                    if (is_octal_char(b)) begin
                        emit_decoded({held_hi, held_mid, 3'(b - CH_ZERO)});
                    end else begin
                        emit_decoded(CH_ZERO + 8'(held_hi));
                        emit_decoded(CH_ZERO + 8'(held_mid));
                        take_plain(b);
                    end
                end
            endcase
        end

        // A string that ends inside an escape gives back the digits it held.
        if (is_last && !string_ended) begin
            if (esc_phase == PH_ONE) begin
                emit_decoded(CH_ZERO + 8'(held_hi));
            end else if (esc_phase == PH_TWO) begin
                emit_decoded(CH_ZERO + 8'(held_hi));
                emit_decoded(CH_ZERO + 8'(held_mid));
            end
        end

        if (is_last) begin
            if (step_words.size() == 0) begin
                step_words.push_back('{data: 8'h00, has_data: 1'b0, last: 1'b1,
                                       count: reported_count()});
            end else begin
                step_words[step_words.size() - 1].last = 1'b1;
            end
            clear_state();
        end

        foreach (step_words[k]) expected_words.push_back(step_words[k]);
    endtask

    always @(posedge i_clk) begin
        decoded_word_t got;
        decoded_word_t want;
        if (!i_rst_n) begin
            clear_state();
            expected_words.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_byte(i_in_mon.in_byte, i_in_mon.in_last);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{data: i_out_mon.out_byte, has_data: i_out_mon.has_byte,
                        last: i_out_mon.out_last, count: i_out_mon.byte_count};
                if (expected_words.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("unexpected word: byte %h has_byte %b last %b count %0d",
                                 got.data, got.has_data, got.last, got.count);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (got.data !== want.data || got.has_data !== want.has_data ||
                        got.last !== want.last || got.count !== want.count) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("word mismatch: expected byte %h has_byte %b last %b count %0d",
                                     want.data, want.has_data, want.last, want.count);
                            $display("                    got byte %h has_byte %b last %b count %0d",
                                     got.data, got.has_data, got.last, got.count);
                        end
                    end
                end
            end
        end
        o_failures <= failures;
        o_pending  <= expected_words.size();
    end

endmodule

@@ dv/bytea_escape_decoder_core_tb.sv @@
// Testbench top for the escape-format binary string decoder: drives escaped strings
// with random gaps and backpressure, and gives the verdict from the checker's counts.
// Depends on bed_pkg, bed_in_if, bed_out_if, bed_decode_check and the decoder core.
module bytea_escape_decoder_core_tb;
    import bed_pkg::*;

    localparam int RANDOM_ITEMS = 330;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 40_000;

    typedef logic [7:0] t_byte_q[$];

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycles = 0;
    int   sent_words = 0;
    int   hold_requests = 0;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    int   check_failures;
    int   check_pending;

    bed_in_if  in_ch ();
    bed_out_if out_ch ();

    bytea_escape_decoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bed_decode_check decode_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_mon   (in_ch),
        .i_out_mon  (out_ch),
        .o_failures (check_failures),
        .o_pending  (check_pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != served) begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= rx_steady || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic is_last);
        while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= is_last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_words++;
    endtask

    task automatic send_string(input t_byte_q s);
        foreach (s[k]) send_word(s[k], k == s.size() - 1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (check_pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(255, 1));
        return (c == CH_BACKSLASH) ? 8'h7E : c;
    endfunction

    task automatic add_token(ref t_byte_q s);
        int pick;
        pick = $urandom_range(19);
        if (pick < 6) begin
            s.push_back(plain_char());
        end else if (pick < 8) begin
            s.push_back(8'($urandom));
        end else if (pick < 10) begin
            s.push_back(CH_BACKSLASH);
            s.push_back(CH_BACKSLASH);
        end else if (pick < 15) begin
            s.push_back(CH_BACKSLASH);
            s.push_back(CH_ZERO + 8'($urandom_range(3)));
            s.push_back(CH_ZERO + 8'($urandom_range(7)));
            s.push_back(CH_ZERO + 8'($urandom_range(7)));
        end else if (pick < 18) begin
            // An escape that is cut short or carries a digit out of range.
            s.push_back(CH_BACKSLASH);
            if ($urandom_range(1)) s.push_back(CH_ZERO + 8'($urandom_range(7)));
            if ($urandom_range(1)) s.push_back(CH_ZERO + 8'($urandom_range(9)));
        end else if (pick == 18) begin
            s.push_back(CH_ZERO + 8'($urandom_range(9)));
        end else begin
            s.push_back(CH_NUL);
        end
    endtask

    initial begin
        t_byte_q rand_str;
        int      directed_words;
        int      n_tokens;
        logic    held;
        held = 1'b0;

        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.in_last <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_string('{CH_BACKSLASH, CH_BACKSLASH, 8'hFF, 8'h01});
        send_string('{CH_BACKSLASH, CH_ZERO + 8'd3, CH_ZERO + 8'd7, CH_ZERO + 8'd7,
                      CH_BACKSLASH, CH_ZERO, CH_ZERO, CH_ZERO});
        send_string('{CH_BACKSLASH, CH_ZERO + 8'd4, CH_BACKSLASH, CH_ZERO + 8'd1,
                      CH_ZERO + 8'd9, CH_BACKSLASH, CH_ZERO + 8'd1, CH_ZERO + 8'd2,
                      8'h78, CH_BACKSLASH});
        send_string('{CH_BACKSLASH, CH_ZERO + 8'd2, CH_NUL, 8'h62, 8'h63});
        send_string('{CH_BACKSLASH, CH_ZERO + 8'd1, CH_ZERO + 8'd2});
        send_string('{CH_NUL});
        directed_words = sent_words;
        drain();

        while (sent_words < directed_words + RANDOM_ITEMS) begin
            n_tokens = $urandom_range(6, 1);
            rand_str.delete();
            repeat (n_tokens) add_token(rand_str);
            tx_steady = sent_words >= directed_words + 120 && sent_words < directed_words + 200;
            rx_steady = tx_steady;
            if (!held && sent_words >= directed_words + 240) begin
                drain();
                hold_requests++;
                held = 1'b1;
            end
            send_string(rand_str);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain();

        repeat (16) @(posedge i_clk);
        if (check_failures == 0 && check_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
